>>> hw/rtl/ptd_pkg.sv
// Package for the planar tile decoder: sizes, format codes, FSM states,
// controller/datapath command and status types, and the row decode helpers.
// No dependencies.
package ptd_pkg;

  // Tile geometry.
  localparam int TILE_ROWS   = 8;
  localparam int ROW_W       = $clog2(TILE_ROWS);
  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SEL_W       = 3;

  // Format codes of the format register.
  localparam logic [2:0] FMT_1BPP        = 3'd0;
  localparam logic [2:0] FMT_2BPP_IL     = 3'd1;
  localparam logic [2:0] FMT_2BPP_SPLIT  = 3'd2;
  localparam logic [2:0] FMT_4BPP_PLANAR = 3'd3;
  localparam logic [2:0] FMT_4BPP_PACKED = 3'd4;
  localparam logic [2:0] FMT_BYTE        = 3'd5;
  localparam logic [2:0] FMT_8BPP_PLANAR = 3'd6;

  typedef logic [7:0][7:0] pix_row_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_READ,
    ST_WAIT,
    ST_EMIT
  } ptd_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load_byte;
    logic              rd_en;
    logic [ROW_W-1:0]  rd_row;
    logic [SEL_W-1:0]  rd_sel;
    logic              emit;
    logic [ROW_W-1:0]  emit_row;
  } ptd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic              tile_end;
    logic [SEL_W-1:0]  reads_last;
    logic              out_free;
  } ptd_status_t;

  // Index of the last byte of a tile in the given format.
  function automatic logic [ADDR_W-1:0] fmt_last_byte(input logic [2:0] fmt);
    logic [ADDR_W-1:0] last;
    case (fmt)
      FMT_1BPP:        last = ADDR_W'(7);
      FMT_2BPP_IL:     last = ADDR_W'(15);
      FMT_2BPP_SPLIT:  last = ADDR_W'(15);
      FMT_4BPP_PLANAR: last = ADDR_W'(31);
      FMT_4BPP_PACKED: last = ADDR_W'(31);
      default:         last = ADDR_W'(63);
    endcase
    return last;
  endfunction

  // Number of store reads per row, minus one.
  function automatic logic [SEL_W-1:0] fmt_reads_last(input logic [2:0] fmt);
    logic [SEL_W-1:0] n;
    case (fmt)
      FMT_1BPP:        n = SEL_W'(0);
      FMT_2BPP_IL:     n = SEL_W'(1);
      FMT_2BPP_SPLIT:  n = SEL_W'(1);
      FMT_4BPP_PLANAR: n = SEL_W'(3);
      FMT_4BPP_PACKED: n = SEL_W'(3);
      default:         n = SEL_W'(7);
    endcase
    return n;
  endfunction

  // Store address of read number sel of row r.
  function automatic logic [ADDR_W-1:0] rd_addr(input logic [2:0] fmt,
                                                input logic [ROW_W-1:0] r,
                                                input logic [SEL_W-1:0] sel);
    logic [ADDR_W-1:0] a;
    case (fmt)
      FMT_1BPP:        a = {3'b000, r};
      FMT_2BPP_IL:     a = {2'b00, r, sel[0]};
      FMT_2BPP_SPLIT:  a = {2'b00, sel[0], r};
      FMT_4BPP_PLANAR: a = {sel[2:1], r, sel[0]};
      FMT_8BPP_PLANAR: a = {sel[2:1], r, sel[0]};
      FMT_4BPP_PACKED: a = {1'b0, r, sel[1:0]};
      default:         a = {r, sel};
    endcase
    return a;
  endfunction

  // Merge one store byte into the row being built. The first read of a row
  // starts from zero instead of the old row.
  function automatic pix_row_t row_merge(input logic [2:0] fmt,
                                         input logic [SEL_W-1:0] sel,
                                         input logic [7:0] b,
                                         input pix_row_t acc);
    pix_row_t px;
    px = (sel == '0) ? '0 : acc;
    case (fmt)
      FMT_1BPP, FMT_2BPP_IL, FMT_2BPP_SPLIT, FMT_4BPP_PLANAR, FMT_8BPP_PLANAR: begin
        // Plane number equals the read number; MSB is the left pixel.
        for (int x = 0; x < 8; x++) begin
          px[x][sel] = b[7-x];
        end
      end
      FMT_4BPP_PACKED: begin
        px[{sel[1:0], 1'b0}] = {4'h0, b[7:4]};
        px[{sel[1:0], 1'b1}] = {4'h0, b[3:0]};
      end
      default: begin
        px[sel] = b;
      end
    endcase
    return px;
  endfunction

endpackage

>>> hw/rtl/ptd_intf.sv
// Valid/ready channel interfaces of the planar tile decoder: byte input,
// row output and configuration write. Depends on ptd_pkg.
interface ptd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface ptd_row_if import ptd_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_index;
  logic [7:0]       pixel_0;
  logic [7:0]       pixel_1;
  logic [7:0]       pixel_2;
  logic [7:0]       pixel_3;
  logic [7:0]       pixel_4;
  logic [7:0]       pixel_5;
  logic [7:0]       pixel_6;
  logic [7:0]       pixel_7;
  logic             last_row;
  modport source (output valid, output row_index, output pixel_0, output pixel_1,
                  output pixel_2, output pixel_3, output pixel_4, output pixel_5,
                  output pixel_6, output pixel_7, output last_row, input ready);
  modport sink   (input valid, input row_index, input pixel_0, input pixel_1,
                  input pixel_2, input pixel_3, input pixel_4, input pixel_5,
                  input pixel_6, input pixel_7, input last_row, output ready);
endinterface

interface ptd_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] format_code;
  modport source (output valid, output format_code, input ready);
  modport sink   (input valid, input format_code, output ready);
endinterface

>>> hw/rtl/ptd_ctrl.sv
// Controller of the planar tile decoder: sequences byte loading, the store
// reads of each row and the row hand-off. Depends on ptd_pkg.
module ptd_ctrl import ptd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  ptd_status_t status,
  output ptd_cmd_t    cmd
);

  ptd_state_t       state, state_next;
  logic [ROW_W-1:0] row, row_next;
  logic [SEL_W-1:0] sel, sel_next;

  // State, row and read counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      row   <= '0;
      sel   <= '0;
    end else begin
      state <= state_next;
      row   <= row_next;
      sel   <= sel_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next    = state;
    row_next      = row;
    sel_next      = sel;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.rd_row    = row;
    cmd.rd_sel    = sel;
    cmd.emit_row  = row;
    case (state)
      ST_LOAD: begin
        in_ready      = 1'b1;
        cmd.load_byte = in_valid;
        if (in_valid && status.tile_end) begin
          state_next = ST_READ;
          row_next   = '0;
          sel_next   = '0;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        if (sel == status.reads_last) begin
          state_next = ST_WAIT;
          sel_next   = '0;
        end else begin
          sel_next = sel + SEL_W'(1);
        end
      end
      ST_WAIT: begin
        // The last byte of the row is merged during this cycle.
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (row == ROW_W'(TILE_ROWS - 1)) begin
            state_next = ST_LOAD;
          end else begin
            row_next   = row + ROW_W'(1);
            state_next = ST_READ;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

>>> hw/rtl/ptd_datapath.sv
// Datapath of the planar tile decoder: format register, byte counter, the
// 64-byte tile store, row merge and the output register. Depends on ptd_pkg.
module ptd_datapath import ptd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic [2:0]       cfg_format,
  input  logic [7:0]       data_byte,
  input  ptd_cmd_t         cmd,
  output ptd_status_t      status,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [ROW_W-1:0] out_row,
  output pix_row_t         out_pix,
  output logic             out_last
);

  logic [2:0]        format_code;
  logic [ADDR_W-1:0] byte_count;
  logic [7:0]        store [STORE_DEPTH];
  logic [7:0]        rd_data;
  logic              rd_vld;
  logic [SEL_W-1:0]  rd_sel;
  pix_row_t          acc;
  logic              tile_end;

  assign tile_end = (byte_count >= fmt_last_byte(format_code));

  assign status.tile_end   = tile_end;
  assign status.reads_last = fmt_reads_last(format_code);
  assign status.out_free   = !out_valid || out_ready;

  // Format register and byte counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      format_code <= FMT_1BPP;
      byte_count  <= '0;
    end else begin
      if (cfg_valid) begin
        format_code <= cfg_format;
      end
      if (cmd.load_byte) begin
        byte_count <= tile_end ? '0 : byte_count + ADDR_W'(1);
      end
    end
  end

  // Tile store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      store[byte_count] <= data_byte;
    end
    if (cmd.rd_en) begin
      rd_data <= store[rd_addr(format_code, cmd.rd_row, cmd.rd_sel)];
    end
  end

  // Read tag travels with the store data.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_en;
    end
    rd_sel <= cmd.rd_sel;
  end

  // Row accumulator.
  always_ff @(posedge clk) begin
    if (rd_vld) begin
      acc <= row_merge(format_code, rd_sel, rd_data, acc);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      out_row  <= cmd.emit_row;
      out_pix  <= acc;
      out_last <= (cmd.emit_row == ROW_W'(TILE_ROWS - 1));
    end
  end

endmodule

>>> hw/rtl/planar_tile_decoder_8x8.sv
// Top level of the planar tile decoder: controller plus datapath behind
// valid/ready channels. Depends on ptd_pkg, ptd_intf, ptd_ctrl, ptd_datapath.
//
//  channel     dir  word                                       handshake
//  tile_bytes  in   data_byte[7:0]                             valid/ready
//  rows        out  row_index[2:0], pixel_0..7[7:0], last_row  valid/ready
//  cfg         in   format_code[2:0]                           valid/ready
//
// Loading takes 8, 16, 32 or 64 bytes per tile. Each row then takes R store
// reads (R = 1, 2, 4 or 8) from the single store read port, one byte a cycle,
// then a wait step and an emit step. Bytes are not accepted
// while rows are decoded; the last row may wait in the output register while
// the next tile loads. Output stalls hold the decoder in its emit step.
// Reset clears the format to 1bpp and the byte count; the store is not reset.
module planar_tile_decoder_8x8 import ptd_pkg::*; (
  input logic        clk,
  input logic        rst,
  ptd_byte_if.sink   tile_bytes,
  ptd_row_if.source  rows,
  ptd_cfg_if.sink    cfg
);

  ptd_cmd_t    cmd;
  ptd_status_t status;
  pix_row_t    out_pix;

  assign cfg.ready = 1'b1;

  ptd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (tile_bytes.valid),
    .in_ready (tile_bytes.ready),
    .status   (status),
    .cmd      (cmd)
  );

  ptd_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg.valid),
    .cfg_format (cfg.format_code),
    .data_byte  (tile_bytes.data_byte),
    .cmd        (cmd),
    .status     (status),
    .out_ready  (rows.ready),
    .out_valid  (rows.valid),
    .out_row    (rows.row_index),
    .out_pix    (out_pix),
    .out_last   (rows.last_row)
  );

  // Pixel fields, leftmost first.
  assign rows.pixel_0 = out_pix[0];
  assign rows.pixel_1 = out_pix[1];
  assign rows.pixel_2 = out_pix[2];
  assign rows.pixel_3 = out_pix[3];
  assign rows.pixel_4 = out_pix[4];
  assign rows.pixel_5 = out_pix[5];
  assign rows.pixel_6 = out_pix[6];
  assign rows.pixel_7 = out_pix[7];

endmodule

>>> hw/rtl/ptd_checker.sv
// Port-level checks of the planar tile decoder and their bind to the top
// level. Depends on ptd_pkg and planar_tile_decoder_8x8.
module ptd_checker import ptd_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ROW_W-1:0] row_index,
  input logic [7:0]       pixel_0,
  input logic             last_row
);

  logic [ROW_W-1:0] exp_row;

  // Expected row number of the next word on the row channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_row <= '0;
    end else if (out_valid && out_ready) begin
      exp_row <= last_row ? '0 : row_index + ROW_W'(1);
    end
  end

  // Rows come out in order, top row first.
  a_row_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> row_index == exp_row)
    else $error("row word out of order");

  // The last-row flag marks exactly the bottom row.
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_row == (row_index == ROW_W'(TILE_ROWS - 1))))
    else $error("last_row does not match row_index");

  // While a row other than the last is offered, the decoder is still busy
  // and takes no bytes.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_row |-> !in_ready)
    else $error("byte input open while rows remain");

  // A stalled row word stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("row word dropped while stalled");

  // A stalled row word keeps its row index and its first pixel.
  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(row_index) && $stable(pixel_0))
    else $error("row word changed while stalled");

endmodule

bind planar_tile_decoder_8x8 ptd_checker u_ptd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (tile_bytes.ready),
  .out_valid (rows.valid),
  .out_ready (rows.ready),
  .row_index (rows.row_index),
  .pixel_0   (rows.pixel_0),
  .last_row  (rows.last_row)
);

>>> verif/ptd_row_check.sv
`timescale 1ns / 100ps
// Row checker for the planar tile decoder: watches the byte, row and format
// channels, predicts the decoded rows of each tile and compares them.
// Depends on ptd_pkg and ptd_intf.
module ptd_row_check import ptd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  ptd_byte_if   byte_ch,
  ptd_row_if    row_ch,
  ptd_cfg_if    cfg_ch,
  output int    fail_count,
  output int    rows_pending
);

  // One decoded row word as the block should deliver it; pixels[x] is column x.
  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    pix_row_t         pixels;
    logic             last_row;
  } row_word_t;

  logic [7:0]        tile_mem [STORE_DEPTH];
  logic [ADDR_W-1:0] fill_count;
  logic [2:0]        cur_fmt;
  row_word_t         expected_rows [$];

  // Index of the last byte of a tile; the unused code acts as one byte per pixel.
  function automatic logic [ADDR_W-1:0] tile_last(input logic [2:0] fmt);
    case (fmt)
      FMT_1BPP:                        return ADDR_W'(7);
      FMT_2BPP_IL, FMT_2BPP_SPLIT:     return ADDR_W'(15);
      FMT_4BPP_PLANAR, FMT_4BPP_PACKED: return ADDR_W'(31);
      default:                         return ADDR_W'(63);
    endcase
  endfunction

  // Set bit plane of every pixel from one plane byte, MSB being the left pixel.
  function automatic pix_row_t or_plane(input pix_row_t px, input logic [7:0] b,
                                        input int plane);
    pix_row_t res;
    int x;
    res = px;
    for (x = 0; x < 8; x++) begin
      res[x][plane] = res[x][plane] | b[7-x];
    end
    return res;
  endfunction

  // Colour indices of tile row r in the given format.
  function automatic pix_row_t decode_row(input logic [2:0] fmt, input int r);
    pix_row_t px;
    logic [7:0] b;
    int x, p, base, planes;
    px = '0;
    case (fmt)
      FMT_1BPP: begin
        px = or_plane(px, tile_mem[r], 0);
      end
      FMT_2BPP_IL: begin
        px = or_plane(px, tile_mem[2*r], 0);
        px = or_plane(px, tile_mem[2*r+1], 1);
      end
      FMT_2BPP_SPLIT: begin
        px = or_plane(px, tile_mem[r], 0);
        px = or_plane(px, tile_mem[r+8], 1);
      end
      FMT_4BPP_PLANAR, FMT_8BPP_PLANAR: begin
        // Plane pairs sit 16 bytes apart.
        planes = (fmt == FMT_4BPP_PLANAR) ? 4 : 8;
        for (p = 0; p < planes; p += 2) begin
          base = 2*r + 8*p;
          px = or_plane(px, tile_mem[base], p);
          px = or_plane(px, tile_mem[base+1], p+1);
        end
      end
      FMT_4BPP_PACKED: begin
        // High nibble is the left pixel of each pair.
        for (x = 0; x < 8; x++) begin
          b = tile_mem[4*r + x/2];
          px[x] = (x % 2 == 1) ? {4'h0, b[3:0]} : {4'h0, b[7:4]};
        end
      end
      default: begin
        for (x = 0; x < 8; x++) begin
          px[x] = tile_mem[8*r + x];
        end
      end
    endcase
    return px;
  endfunction

  // Store one accepted byte; the byte that ends the tile queues all eight rows.
  task automatic store_byte(input logic [7:0] b);
    int r;
    tile_mem[fill_count] = b;
    if (fill_count < tile_last(cur_fmt)) begin
      fill_count = fill_count + 1'b1;
    end else begin
      fill_count = '0;
      for (r = 0; r < TILE_ROWS; r++) begin
        expected_rows.push_back('{row_index: ROW_W'(r),
                                  pixels:    decode_row(cur_fmt, r),
                                  last_row:  (r == TILE_ROWS - 1)});
      end
    end
  endtask

  // Compare one accepted row word with the oldest expected row.
  task automatic check_row();
    row_word_t want;
    pix_row_t got;
    int x;
    got = {row_ch.pixel_7, row_ch.pixel_6, row_ch.pixel_5, row_ch.pixel_4,
           row_ch.pixel_3, row_ch.pixel_2, row_ch.pixel_1, row_ch.pixel_0};
    if (expected_rows.size() == 0) begin
      fail_count++;
      $display("%0t: row word with no row expected, row_index %0d",
               $time, row_ch.row_index);
    end else begin
      want = expected_rows.pop_front();
      if (row_ch.row_index !== want.row_index) begin
        fail_count++;
        $display("%0t: row_index expected %0d, actual %0d",
                 $time, want.row_index, row_ch.row_index);
      end
      for (x = 0; x < 8; x++) begin
        if (got[x] !== want.pixels[x]) begin
          fail_count++;
          $display("%0t: row %0d pixel_%0d expected %0d, actual %0d",
                   $time, want.row_index, x, want.pixels[x], got[x]);
        end
      end
      if (row_ch.last_row !== want.last_row) begin
        fail_count++;
        $display("%0t: row %0d last_row expected %0d, actual %0d",
                 $time, want.row_index, want.last_row, row_ch.last_row);
      end
    end
  endtask

  // Handshakes are sampled at the clock edge: format first, then bytes, then rows.
  always @(posedge clk) begin
    if (rst) begin
      fill_count = '0;
      cur_fmt    = FMT_1BPP;
      fail_count = 0;
      expected_rows.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        cur_fmt = cfg_ch.format_code;
      end
      if (byte_ch.valid && byte_ch.ready) begin
        store_byte(byte_ch.data_byte);
      end
      if (row_ch.valid && row_ch.ready) begin
        check_row();
      end
    end
    rows_pending = expected_rows.size();
  end

endmodule

>>> verif/planar_tile_decoder_8x8_test.sv
`timescale 1ns / 100ps
// Testbench top for the planar tile decoder: drives tile bytes, format writes
// and row back-pressure, and gives the verdict. Depends on ptd_pkg, ptd_intf,
// the decoder RTL and ptd_row_check.
module planar_tile_decoder_8x8_test;
  import ptd_pkg::*;

  localparam logic [2:0] FMT_UNUSED = 3'd7;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 50;
  localparam int RANDOM_TILES  = 4;

  logic clk;
  logic rst;
  int   fail_count;
  int   rows_pending;
  int   cycle_count;
  logic calm;
  logic hold_req;
  logic hold_done;

  ptd_byte_if tile_bytes();
  ptd_row_if  rows();
  ptd_cfg_if  cfg();

  planar_tile_decoder_8x8 i_dut (
    .clk        (clk),
    .rst        (rst),
    .tile_bytes (tile_bytes),
    .rows       (rows),
    .cfg        (cfg)
  );

  ptd_row_check i_row_check (
    .clk          (clk),
    .rst          (rst),
    .byte_ch      (tile_bytes),
    .row_ch       (rows),
    .cfg_ch       (cfg),
    .fail_count   (fail_count),
    .rows_pending (rows_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("planar_tile_decoder_8x8_test NOT OK");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Byte value: random, with the edge patterns favored.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h01;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int tile_len(input logic [2:0] fmt);
    case (fmt)
      FMT_1BPP:                        return 8;
      FMT_2BPP_IL, FMT_2BPP_SPLIT:     return 16;
      FMT_4BPP_PLANAR, FMT_4BPP_PACKED: return 32;
      default:                         return 64;
    endcase
  endfunction

  // Row receiver: random stalls, one long hold-off on request.
  initial begin
    rows.ready <= 1'b0;
    hold_done = 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) begin
          rows.ready <= 1'b0;
          @(posedge clk);
        end
      end else if (calm || $urandom_range(0, 3) != 0) begin
        rows.ready <= 1'b1;
        @(posedge clk);
      end else begin
        repeat (pick_gap() + 1) begin
          rows.ready <= 1'b0;
          @(posedge clk);
        end
      end
    end
  end

  // Offer one byte after a random gap and return at the edge that takes it.
  // Ready is sampled at the falling edge, where it is settled.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    logic taken;
    gap = pick_gap();
    repeat (gap) begin
      tile_bytes.valid <= 1'b0;
      @(posedge clk);
    end
    tile_bytes.valid     <= 1'b1;
    tile_bytes.data_byte <= b;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = tile_bytes.ready;
      @(posedge clk);
    end
  endtask

  task automatic send_random(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      send_byte(pick_byte());
    end
  endtask

  // Write the format once every expected row is out and the block has settled.
  task automatic write_format(input logic [2:0] fmt);
    logic taken;
    tile_bytes.valid <= 1'b0;
    do @(negedge clk); while (rows_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg.valid       <= 1'b1;
    cfg.format_code <= fmt;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = cfg.ready;
      @(posedge clk);
    end
    cfg.valid <= 1'b0;
  endtask

  // Stimulus and verdict.
  initial begin
    int tile_no;
    logic [2:0] fmt;
    logic [2:0] cur_fmt;
    rst                  <= 1'b1;
    tile_bytes.valid     <= 1'b0;
    tile_bytes.data_byte <= 8'h00;
    cfg.valid            <= 1'b0;
    cfg.format_code      <= FMT_1BPP;
    calm                 = 1'b0;
    hold_req             = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A 1bpp tile in the reset format with the edge byte patterns, then a
    // second tile offered back to back while the receiver holds off, so that
    // the block fills up and stalls its input.
    calm     = 1'b1;
    hold_req = 1'b1;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'h0F);
    send_byte(8'hF0);
    send_random(8);
    calm     = 1'b0;

    // Shrink the format mid-tile with the count exactly at the new last byte,
    // then with the count past it: the next byte ends the tile either way.
    write_format(FMT_BYTE);
    send_random(7);
    write_format(FMT_1BPP);
    send_random(1);
    write_format(FMT_BYTE);
    send_random(9);
    write_format(FMT_1BPP);
    send_random(1);
    cur_fmt  = FMT_1BPP;

    // One tile in each 2bpp format, then one 4bpp format and one 64-byte
    // format code picked at random.
    for (tile_no = 0; tile_no < RANDOM_TILES; tile_no++) begin
      case (tile_no)
        0:       fmt = FMT_2BPP_IL;
        1:       fmt = FMT_2BPP_SPLIT;
        2:       fmt = 3'($urandom_range(32'(FMT_4BPP_PLANAR), 32'(FMT_4BPP_PACKED)));
        default: fmt = 3'($urandom_range(32'(FMT_BYTE), 32'(FMT_UNUSED)));
      endcase
      if (fmt != cur_fmt) begin
        write_format(fmt);
        cur_fmt = fmt;
      end
      calm = ($urandom_range(0, 4) == 0);
      send_random(tile_len(fmt));
    end

    // Drain and verdict.
    calm = 1'b0;
    tile_bytes.valid <= 1'b0;
    do @(negedge clk); while (rows_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("planar_tile_decoder_8x8_test OK");
    end else begin
      $display("planar_tile_decoder_8x8_test NOT OK");
    end
    $finish;
  end

endmodule
